### rtl/core/dfjd_pkg.sv
// Shared constants, types and lookup for the day-number to calendar-date pipeline.
package dfjd_pkg;

    localparam int NSTAGE = 10;

    localparam logic [22:0] GREG_START     = 23'd2299161;
    localparam logic [24:0] ALPHA_OFS_X4   = 25'd7468865;
    localparam logic [17:0] GREG_CYCLE     = 18'd146097;
    localparam logic [14:0] ALPHA_RECIP    = 15'((64'd1 << 32) / 64'd146097);
    localparam logic [23:0] DAY_OFS        = 24'd1524;
    localparam logic [27:0] C_OFS_X20      = 28'd2442;
    localparam logic [12:0] YEAR_LEN_X20   = 13'd7305;
    localparam logic [19:0] YEAR_RECIP     = 20'((64'd1 << 32) / 64'd7305);
    localparam logic [10:0] YEAR_LEN_X4    = 11'd1461;
    localparam logic [18:0] MONTH_NUM      = 19'd306001;
    localparam logic [13:0] MONTH_DEN      = 14'd10000;
    localparam logic [19:0] MONTH_RECIP    = 20'((64'd10000 << 24) / 64'd306001);
    localparam logic [15:0] YEAR_OFS_LATE  = 16'd4716;
    localparam logic [15:0] YEAR_OFS_EARLY = 16'd4715;
    localparam logic [4:0]  E_WRAP         = 5'd14;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } greg_en_t;

    // floor(30.6001 * e)
    function automatic logic [8:0] month_start(input logic [3:0] e);
        logic [8:0] r;
        case (e)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd30;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd91;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd183;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd336;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd397;
            4'd14:   r = 9'd428;
            default: r = 9'd459;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/dfjd_greg.sv
// Gregorian correction stages: day number to shifted day count B (three stages).
module dfjd_greg (
    input  logic               aclk,
    input  dfjd_pkg::greg_en_t en,
    input  logic [22:0]        z,
    output logic [23:0]        b
);
    import dfjd_pkg::*;

    logic [24:0] x;
    logic [39:0] p1;
    logic [22:0] z1_reg, z2_reg;
    logic        greg1_reg, greg2_reg;
    logic [24:0] x1_reg, x2_reg;
    logic [39:0] p1_reg;
    logic [7:0]  q2_reg;
    logic [25:0] prod2_reg;
    logic [23:0] b3_reg;
    logic [7:0]  q0;
    logic [25:0] prod;
    logic [25:0] rem;
    logic [7:0]  alpha;
    logic [23:0] a;

    always_comb begin
        x    = {z, 2'b00} - ALPHA_OFS_X4;
        p1   = 40'(x) * 40'(ALPHA_RECIP);
        q0   = p1_reg[39:32];
        prod = 26'(q0) * 26'(GREG_CYCLE);
        rem  = 26'(x2_reg) - prod2_reg;
        alpha = q2_reg + 8'(rem >= 26'(GREG_CYCLE));
        if (greg2_reg) begin
            a = 24'(z2_reg) + 24'd1 + 24'(alpha) - 24'(alpha[7:2]);
        end else begin
            a = 24'(z2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            z1_reg    <= z;
            greg1_reg <= (z >= GREG_START);
            x1_reg    <= x;
            p1_reg    <= p1;
        end
        if (en.s2) begin
            z2_reg    <= z1_reg;
            greg2_reg <= greg1_reg;
            x2_reg    <= x1_reg;
            q2_reg    <= q0;
            prod2_reg <= prod;
        end
        if (en.s3) begin
            b3_reg <= a + DAY_OFS;
        end
    end

    assign b = b3_reg;

endmodule

### rtl/core/date_from_julian_day.sv
// Top level: pipelined Julian day number to calendar year, month and day.
// Ten register stages carry each accepted item from s_ to m_.
// Throughput: one item per cycle while m_ready is high; each stage holds at most
// two constant multiplies and one compare-and-correct, and a stall holds only full
// stages while bubbles fill.
// Reset (aresetn low, synchronous) clears all stage valid bits; payload is unreset.
module date_from_julian_day (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [22:0]        s_day_number,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_year_out,
    output logic [3:0]         m_month_out,
    output logic [4:0]         m_day_out
);
    import dfjd_pkg::*;

    logic [NSTAGE:1] v_reg, v_next;
    logic [NSTAGE:1] en;
    greg_en_t        greg_en;
    logic [23:0]     b3;

    logic [23:0] b4_reg, b5_reg, b6_reg;
    logic [27:0] y4_reg, y5_reg;
    logic [47:0] p4_reg;
    logic [14:0] c5_reg, c6_reg, c7_reg, c8_reg, c9_reg;
    logic [27:0] cp5_reg;
    logic [9:0]  bd7_reg, bd8_reg, bd9_reg;
    logic [4:0]  e8_reg, e9_reg;
    logic signed [15:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    logic [27:0] y;
    logic [47:0] p4;
    logic [27:0] cp;
    logic [27:0] yrem;
    logic [14:0] c;
    logic [25:0] dprod;
    logic [23:0] bd;
    logic [29:0] p8;
    logic [23:0] n9, m9, erem;
    logic [4:0]  e;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] year;

    // stage enables: a stage loads when it is empty or its successor loads
    always_comb begin
        en[NSTAGE] = !v_reg[NSTAGE] || m_ready;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k + 1];
        end
        v_next[1] = en[1] ? s_valid : v_reg[1];
        for (int k = 2; k <= NSTAGE; k++) begin
            v_next[k] = en[k] ? v_reg[k - 1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign greg_en = '{s1: en[1], s2: en[2], s3: en[3]};

    dfjd_greg u_greg (
        .aclk (aclk),
        .en   (greg_en),
        .z    (s_day_number),
        .b    (b3)
    );

    always_comb begin
        y     = 28'(b3) * 28'd20 - C_OFS_X20;
        p4    = 48'(y) * 48'(YEAR_RECIP);
        cp    = 28'(p4_reg[46:32]) * 28'(YEAR_LEN_X20);
        yrem  = y5_reg - cp5_reg;
        c     = c5_reg + 15'(yrem >= 28'(YEAR_LEN_X20));
        dprod = 26'(c6_reg) * 26'(YEAR_LEN_X4);
        bd    = b6_reg - 24'(dprod[25:2]);
        p8    = 30'(bd7_reg) * 30'(MONTH_RECIP);
        n9    = 24'(bd8_reg) * 24'(MONTH_DEN);
        m9    = 24'(e8_reg) * 24'(MONTH_NUM);
        erem  = n9 - m9;
        e     = e8_reg + 5'(erem >= 24'(MONTH_NUM));
        day   = 5'(bd9_reg - 10'(month_start(e9_reg[3:0])));
        if (e9_reg < E_WRAP) begin
            month = 4'(e9_reg - 5'd1);
        end else begin
            month = 4'(e9_reg - 5'd13);
        end
        if (month > 4'd2) begin
            year = 16'(c9_reg) - YEAR_OFS_LATE;
        end else begin
            year = 16'(c9_reg) - YEAR_OFS_EARLY;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            b4_reg <= b3;
            y4_reg <= y;
            p4_reg <= p4;
        end
        if (en[5]) begin
            b5_reg  <= b4_reg;
            y5_reg  <= y4_reg;
            c5_reg  <= p4_reg[46:32];
            cp5_reg <= cp;
        end
        if (en[6]) begin
            b6_reg <= b5_reg;
            c6_reg <= c;
        end
        if (en[7]) begin
            c7_reg  <= c6_reg;
            bd7_reg <= bd[9:0];
        end
        if (en[8]) begin
            c8_reg  <= c7_reg;
            bd8_reg <= bd7_reg;
            e8_reg  <= p8[28:24];
        end
        if (en[9]) begin
            c9_reg  <= c8_reg;
            bd9_reg <= bd8_reg;
            e9_reg  <= e;
        end
        if (en[10]) begin
            year_reg  <= signed'(year);
            month_reg <= month;
            day_reg   <= day;
        end
    end

    assign s_ready     = en[1];
    assign m_valid     = v_reg[NSTAGE];
    assign m_year_out  = year_reg;
    assign m_month_out = month_reg;
    assign m_day_out   = day_reg;

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month_out >= 4'd1) && (m_month_out <= 4'd12))
        else $error("month out of range");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_day_out >= 5'd1) && (m_day_out <= 5'd31))
        else $error("day out of range");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[1])
        else $error("accepted item not in first stage");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

### tb/sv/testbench.sv
// Testbench for date_from_julian_day: directed and random day numbers checked against a date predictor.
`timescale 1ns / 1ps

module testbench;

    localparam longint GREG_FIRST_DAY = 2299161;
    localparam longint ALPHA_BIAS_X4  = 7468865;
    localparam longint GREG_CYCLE     = 146097;
    localparam longint EPOCH_SHIFT    = 1524;
    localparam longint YEAR_BIAS_X20  = 2442;
    localparam longint YEAR_DAYS_X20  = 7305;
    localparam longint YEAR_DAYS_X4   = 1461;
    localparam longint MONTH_SCALE    = 306001;
    localparam longint MONTH_UNIT     = 10000;
    localparam longint YEAR_BASE_LATE = 4716;
    localparam longint YEAR_BASE_EARLY = 4715;
    localparam longint MARCH          = 3;
    localparam logic [22:0] DAY_MAX   = 23'h7FFFFF;
    localparam int RANDOM_PER_PHASE   = 250;
    localparam int DRAIN_CYCLES       = 20;

    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } civil_date_t;

    function automatic civil_date_t civil_date_of(input logic [22:0] day_num);
        longint z, a, b, c, d, e, alpha, mon;
        civil_date_t r;
        z = longint'(day_num);
        if (z < GREG_FIRST_DAY) begin
            a = z;
        end else begin
            alpha = (4 * z - ALPHA_BIAS_X4) / GREG_CYCLE;
            a = z + 1 + alpha - alpha / 4;
        end
        b = a + EPOCH_SHIFT;
        c = (20 * b - YEAR_BIAS_X20) / YEAR_DAYS_X20;
        d = (YEAR_DAYS_X4 * c) / 4;
        e = (MONTH_UNIT * (b - d)) / MONTH_SCALE;
        r.day = 5'(b - d - (MONTH_SCALE * e) / MONTH_UNIT);
        mon = (e < 14) ? e - 1 : e - 13;
        r.month = 4'(mon);
        r.year = 16'((mon >= MARCH) ? c - YEAR_BASE_LATE : c - YEAR_BASE_EARLY);
        return r;
    endfunction

    class date_scoreboard;
        civil_date_t due[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            errors++;
            $display("ERROR at %0t ns: %s", $time, msg);
        endtask

        task note_input(input logic [22:0] day_num);
            due.push_back(civil_date_of(day_num));
        endtask

        task check_result(input logic signed [15:0] year, input logic [3:0] month,
                          input logic [4:0] day);
            civil_date_t want;
            if (due.size() == 0) begin
                report($sformatf("unexpected result %0d-%0d-%0d", year, month, day));
            end else begin
                want = due.pop_front();
                if (year !== want.year)
                    report($sformatf("year %0d, predicted %0d", year, want.year));
                if (month !== want.month)
                    report($sformatf("month %0d, predicted %0d", month, want.month));
                if (day !== want.day)
                    report($sformatf("day %0d, predicted %0d", day, want.day));
            end
        endtask

        function int pending();
            return due.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [22:0]        s_day_number;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_year_out;
    logic [3:0]         m_month_out;
    logic [4:0]         m_day_out;

    int send_idle_pct;
    int recv_stall_pct;
    date_scoreboard sb;

    date_from_julian_day i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_day_number (s_day_number),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_year_out   (m_year_out),
        .m_month_out  (m_month_out),
        .m_day_out    (m_day_out)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_day_number);
            if (m_valid && m_ready)
                sb.check_result(m_year_out, m_month_out, m_day_out);
        end
    end

    task send_day(input logic [22:0] day_num);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_day_number <= day_num;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [22:0] random_day();
        logic [22:0] v;
        case ($urandom_range(9))
            5, 6:    v = 23'($urandom_range(GREG_FIRST_DAY + 2000, GREG_FIRST_DAY - 2000));
            7:       v = 23'($urandom_range(3000));
            8:       v = 23'($urandom_range(2500000, 2400000));
            9:       v = DAY_MAX - 23'($urandom_range(3000));
            default: v = 23'($urandom);
        endcase
        return v;
    endfunction

    logic [22:0] directed_days[] = '{
        23'd0, 23'd1, 23'd59, 23'd60, 23'd365, 23'd366,
        23'd1721057, 23'd1721058, 23'd1721423, 23'd1721424,
        23'd2299159, 23'd2299160, 23'd2299161, 23'd2299162,
        23'd2415020, 23'd2415021, 23'd2451544, 23'd2451545,
        23'd2451603, 23'd2451604, 23'd2451605,
        23'h2AAAAA, 23'h555555, DAY_MAX - 23'd1, DAY_MAX
    };

    int phase_idle[4]  = '{0, 66, 0, 37};
    int phase_stall[4] = '{0, 0, 66, 37};

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_day_number = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_days[i])
            send_day(directed_days[i]);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_day(random_day());
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
